// File: sv/csm_pkg.sv
// Shared constants and opcode codes for the checked stack machine.
`default_nettype none
package csm_pkg;
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 31;
    localparam int LIM_W       = 30;
    localparam int OPND_W      = 32;
    localparam int WIDE_W      = 62;
    localparam int DIV_STEPS   = VAL_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);
    localparam logic [LIM_W-1:0] LIMIT_RESET = 30'd1000000000;

    typedef enum logic [3:0] {
        OP_NUM    = 4'd0,
        OP_POP    = 4'd1,
        OP_INV    = 4'd2,
        OP_DUP    = 4'd3,
        OP_SWP    = 4'd4,
        OP_ADD    = 4'd5,
        OP_SUB    = 4'd6,
        OP_MUL    = 4'd7,
        OP_DIV    = 4'd8,
        OP_MOD    = 4'd9,
        OP_START  = 4'd10,
        OP_FINISH = 4'd11
    } opcode_t;
endpackage
`default_nettype wire

// File: sv/csm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: sv/checked_stack_machine_unit.sv
// Top level of the checked stack machine: sequencer, divider and stack memory.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  input    | in_valid / in_ready | opcode[3:0], operand[31:0] signed
//  output   | out_valid/out_ready | result_value[30:0] signed, result_error
//  config   | cfg_valid/cfg_ready | cfg_data[29:0] (value_limit)
//
// One word is handled at a time. DIV and MOD run a load step and 31 steps of
// the restoring divider, plus the reads, the sign fix and the limit check; a
// zero divisor flags an error and skips the divider. FINISH waits for the
// output register to drain. The stack lives in one RAM with a registered
// read; reset clears the registers but leaves the RAM alone. The limit is
// written only while the machine is idle and no word is offered.
// The output register lets a new word enter while a result waits.
`default_nettype none
module checked_stack_machine_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [3:0]                     opcode,
    input  wire logic signed [csm_pkg::OPND_W-1:0] operand,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [csm_pkg::VAL_W-1:0]    result_value,
    output logic                                result_error,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [csm_pkg::LIM_W-1:0]      cfg_data
);
    import csm_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DEC  = 9'b000000010,
        ST_RB   = 9'b000000100,
        ST_RA   = 9'b000001000,
        ST_WR2  = 9'b000010000,
        ST_CHK  = 9'b000100000,
        ST_DIV  = 9'b001000000,
        ST_DFIX = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    state_t                   state_reg;
    logic [3:0]               op_reg;
    logic signed [OPND_W-1:0] operand_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     err_reg;
    logic [LIM_W-1:0]         limit_reg;
    logic signed [VAL_W-1:0]  a_reg, b_reg;
    logic signed [WIDE_W-1:0] r_reg;
    logic [VAL_W:0]           rem_reg;
    logic [VAL_W-1:0]         quo_reg;
    logic [VAL_W-1:0]         dvs_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     out_valid_reg, out_error_reg;
    logic signed [VAL_W-1:0]  out_value_reg;

    // RAM ports.
    logic              we, re;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [VAL_W-1:0]  wr_data, rd_data;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              full;
    logic              push_ok;
    logic signed [WIDE_W-1:0] push_val;
    logic signed [WIDE_W-1:0] lim_s;
    logic signed [WIDE_W-1:0] product;
    logic [VAL_W:0]    trial;
    logic [VAL_W:0]    shifted;
    logic [VAL_W-1:0]  a_mag, b_mag;
    logic              fin_bad;
    logic              fin_fire;

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign result_error = out_error_reg;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);
    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign lim_s   = WIDE_W'(limit_reg);
    assign product = a_reg * b_reg;
    assign shifted = {rem_reg[VAL_W-1:0], quo_reg[VAL_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign a_mag   = a_reg[VAL_W-1] ? VAL_W'(-a_reg) : VAL_W'(a_reg);
    assign b_mag   = b_reg[VAL_W-1] ? VAL_W'(-b_reg) : VAL_W'(b_reg);
    assign fin_bad = err_reg || (count_reg != CNT_W'(1));

    // FINISH hands its word to the output register once that register is free.
    assign fin_fire = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // Value that a push in the current state would place on the stack.
    // DUP pushes the top word straight from the RAM read port.
    always_comb
    begin
        case (state_reg)
            ST_DEC:  push_val = WIDE_W'(operand_reg);
            ST_RB:   push_val = WIDE_W'($signed(rd_data));
            default: push_val = r_reg;
        endcase
    end

    // A push fails on a magnitude above the limit or, but for START, a full stack.
    assign push_ok = !(push_val > lim_s || push_val < -lim_s) &&
                     (!full || (state_reg == ST_DEC && op_reg == OP_START));

    // Memory control.
    always_comb
    begin
        we      = 1'b0;
        re      = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = push_val[VAL_W-1:0];
        rd_addr = cnt_m1[ADDR_W-1:0];
        case (state_reg)
            ST_DEC:
            begin
                case (op_reg)
                    OP_START:
                    begin
                        we      = push_ok;
                        wr_addr = '0;
                    end
                    OP_FINISH:
                    begin
                        re      = 1'b1;
                        rd_addr = '0;
                    end
                    OP_NUM:
                        we = !err_reg && push_ok;
                    OP_INV, OP_DUP:
                        re = !err_reg && (count_reg != '0);
                    OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                        re = !err_reg && (count_reg >= CNT_W'(2));
                    default: ;
                endcase
            end
            ST_RB:
            begin
                if (op_reg == OP_INV)
                begin
                    we      = 1'b1;
                    wr_addr = cnt_m1[ADDR_W-1:0];
                    wr_data = VAL_W'(-rd_data);
                end
                else if (op_reg == OP_DUP)
                begin
                    we = push_ok;
                end
                else
                begin
                    re      = 1'b1;
                    rd_addr = cnt_m2[ADDR_W-1:0];
                end
            end
            ST_RA:
            begin
                if (op_reg == OP_SWP)
                begin
                    we      = 1'b1;
                    wr_addr = cnt_m1[ADDR_W-1:0];
                    wr_data = rd_data;
                end
            end
            ST_WR2:
            begin
                we      = 1'b1;
                wr_addr = cnt_m2[ADDR_W-1:0];
                wr_data = b_reg;
            end
            ST_CHK:
                we = push_ok;
            default: ;
        endcase
    end

    csm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .re      (re),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            operand_reg   <= '0;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            a_reg         <= '0;
            b_reg         <= '0;
            r_reg         <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            dvs_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_error_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= opcode;
                        operand_reg <= operand;
                        state_reg   <= ST_DEC;
                    end
                end
                ST_DEC:
                begin
                    case (op_reg)
                        OP_START:
                        begin
                            err_reg   <= !push_ok;
                            count_reg <= push_ok ? CNT_W'(1) : '0;
                            state_reg <= ST_IDLE;
                        end
                        OP_FINISH:
                            state_reg <= ST_FIN;
                        OP_NUM:
                        begin
                            state_reg <= ST_IDLE;
                            if (!err_reg)
                            begin
                                if (push_ok)
                                    count_reg <= count_reg + CNT_W'(1);
                                else
                                    err_reg <= 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            state_reg <= ST_IDLE;
                            if (!err_reg)
                            begin
                                if (count_reg == '0)
                                    err_reg <= 1'b1;
                                else
                                    count_reg <= cnt_m1;
                            end
                        end
                        OP_INV, OP_DUP:
                        begin
                            if (!err_reg && count_reg != '0)
                                state_reg <= ST_RB;
                            else
                                state_reg <= ST_IDLE;
                            if (!err_reg && count_reg == '0)
                                err_reg <= 1'b1;
                        end
                        OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                        begin
                            if (!err_reg && count_reg >= CNT_W'(2))
                                state_reg <= ST_RB;
                            else
                                state_reg <= ST_IDLE;
                            if (!err_reg && count_reg < CNT_W'(2))
                                err_reg <= 1'b1;
                        end
                        default:
                            state_reg <= ST_IDLE;
                    endcase
                end
                ST_RB:
                begin
                    b_reg <= rd_data;
                    if (op_reg == OP_DUP)
                    begin
                        state_reg <= ST_IDLE;
                        if (push_ok)
                            count_reg <= count_reg + CNT_W'(1);
                        else
                            err_reg <= 1'b1;
                    end
                    else if (op_reg == OP_INV)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_RA;
                    end
                end
                ST_RA:
                begin
                    a_reg <= rd_data;
                    case (op_reg)
                        OP_SWP:
                            state_reg <= ST_WR2;
                        OP_ADD:
                        begin
                            count_reg <= cnt_m2;
                            r_reg     <= WIDE_W'($signed(rd_data)) + WIDE_W'(b_reg);
                            state_reg <= ST_CHK;
                        end
                        OP_SUB:
                        begin
                            count_reg <= cnt_m2;
                            r_reg     <= WIDE_W'($signed(rd_data)) - WIDE_W'(b_reg);
                            state_reg <= ST_CHK;
                        end
                        OP_MUL:
                        begin
                            // Product is formed from a_reg next cycle.
                            count_reg <= cnt_m2;
                            state_reg <= ST_DFIX;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            count_reg <= cnt_m2;
                            if (b_reg == '0)
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_DIV;
                            end
                        end
                        default:
                            state_reg <= ST_IDLE;
                    endcase
                    step_reg <= '0;
                    rem_reg  <= '0;
                end
                ST_WR2:
                    state_reg <= ST_IDLE;
                ST_DIV:
                begin
                    // Step zero loads the magnitudes, then one quotient bit per cycle.
                    if (step_reg == '0)
                    begin
                        quo_reg  <= a_mag;
                        dvs_reg  <= b_mag;
                        step_reg <= STEP_W'(1);
                    end
                    else
                    begin
                        if (!trial[VAL_W])
                        begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[VAL_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= shifted;
                            quo_reg <= {quo_reg[VAL_W-2:0], 1'b0};
                        end
                        step_reg <= step_reg + STEP_W'(1);
                        if (step_reg == STEP_W'(DIV_STEPS))
                            state_reg <= ST_DFIX;
                    end
                end
                ST_DFIX:
                begin
                    state_reg <= ST_CHK;
                    if (op_reg == OP_MUL)
                        r_reg <= product;
                    else if (op_reg == OP_DIV)
                        r_reg <= (a_reg[VAL_W-1] ^ b_reg[VAL_W-1]) ?
                                 -WIDE_W'(quo_reg) : WIDE_W'(quo_reg);
                    else
                        r_reg <= a_reg[VAL_W-1] ?
                                 -WIDE_W'(rem_reg) : WIDE_W'(rem_reg);
                end
                ST_CHK:
                begin
                    state_reg <= ST_IDLE;
                    if (push_ok)
                        count_reg <= count_reg + CNT_W'(1);
                    else
                        err_reg <= 1'b1;
                end
                ST_FIN:
                begin
                    if (fin_fire)
                    begin
                        out_error_reg <= fin_bad;
                        out_value_reg <= fin_bad ? '0 : rd_data;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_checked_stack_machine_unit.sv
// Self-checking testbench for the checked stack machine: table-driven directed words, then random programs.
`timescale 1ns / 1ps
`default_nettype none
module tb_checked_stack_machine_unit;
    import csm_pkg::*;

    // Clock, reset and the three channels of the block.
    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [3:0] opcode;
    logic signed [OPND_W-1:0] operand;
    logic out_valid;
    logic out_ready;
    logic signed [VAL_W-1:0] result_value;
    logic result_error;
    logic cfg_valid;
    logic cfg_ready;
    logic [LIM_W-1:0] cfg_data;

    checked_stack_machine_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .operand(operand),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .result_error(result_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // A 2 ns clock: one ns high, one ns low.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // One expected FINISH report.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic error;
    } report_t;

    // Mirror of the machine state kept by the testbench.
    logic signed [VAL_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned shadow_depth;
    bit shadow_fault;
    logic [LIM_W-1:0] shadow_limit;

    report_t pending_reports[$];
    int unsigned mismatch_count;
    int unsigned words_sent;
    int unsigned reports_seen;
    int unsigned error_reports;
    int unsigned quiet_cycles;
    bit calm_phase;
    bit drain_done;

    localparam int WATCHDOG_LIMIT = 20000;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic bit beyond_limit(input longint v);
        longint lim;
        lim = longint'(shadow_limit);
        return (v > lim) || (v < -lim);
    endfunction

    // Pushes with the magnitude and depth checks of the machine.
    function automatic void push_value(input longint v);
        if (beyond_limit(v) || shadow_depth >= STACK_DEPTH)
            shadow_fault = 1'b1;
        else
        begin
            shadow_stack[shadow_depth] = VAL_W'(v);
            shadow_depth++;
        end
    endfunction

    // Advances the mirror by one instruction word; returns 1 when a report is due.
    function automatic bit execute_word(input logic [3:0] op, input logic signed [31:0] opnd,
                                        output report_t rep);
        longint a;
        longint b;
        longint r;
        logic signed [VAL_W-1:0] t;
        rep = '0;
        if (op == OP_FINISH)
        begin
            rep.error = shadow_fault || shadow_depth != 1;
            rep.value = rep.error ? '0 : shadow_stack[0];
            return 1'b1;
        end
        if (op == OP_START)
        begin
            shadow_depth = 0;
            shadow_fault = 1'b0;
            push_value(longint'(opnd));
            return 1'b0;
        end
        if (shadow_fault)
            return 1'b0;
        case (op)
            OP_NUM: push_value(longint'(opnd));
            OP_POP:
                if (shadow_depth == 0) shadow_fault = 1'b1;
                else shadow_depth--;
            OP_INV:
                if (shadow_depth == 0) shadow_fault = 1'b1;
                else shadow_stack[shadow_depth-1] = -shadow_stack[shadow_depth-1];
            OP_DUP:
                if (shadow_depth == 0) shadow_fault = 1'b1;
                else push_value(longint'(shadow_stack[shadow_depth-1]));
            OP_SWP:
                if (shadow_depth < 2) shadow_fault = 1'b1;
                else
                begin
                    t = shadow_stack[shadow_depth-1];
                    shadow_stack[shadow_depth-1] = shadow_stack[shadow_depth-2];
                    shadow_stack[shadow_depth-2] = t;
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                if (shadow_depth < 2) shadow_fault = 1'b1;
                else
                begin
                    b = longint'(shadow_stack[shadow_depth-1]);
                    a = longint'(shadow_stack[shadow_depth-2]);
                    shadow_depth -= 2;
                    if ((op == OP_DIV || op == OP_MOD) && b == 0)
                        shadow_fault = 1'b1;
                    else
                    begin
                        // SystemVerilog division truncates toward zero, and the sign
                        // of the remainder follows the dividend, as the machine does.
                        case (op)
                            OP_ADD: r = a + b;
                            OP_SUB: r = a - b;
                            OP_MUL: r = a * b;
                            OP_DIV: r = a / b;
                            default: r = a % b;
                        endcase
                        push_value(r);
                    end
                end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Holds the word on the input channel until the block takes it, with an
    // optional burst of idle cycles in front. Inputs move on falling edges.
    task automatic send_word(input logic [3:0] op, input logic signed [31:0] opnd);
        report_t rep;
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge clk);
        end
        opcode = op;
        operand = opnd;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (execute_word(op, opnd, rep))
            pending_reports = {pending_reports, rep};
        words_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Same as send_word, but also compares against a value typed into the table.
    task automatic send_known(input logic [3:0] op, input logic signed [31:0] opnd,
                              input bit has_known, input report_t known);
        if (has_known && op == OP_FINISH)
        begin
            report_t rep;
            // The predictor must agree with the typed-in figure.
            if (shadow_fault || shadow_depth != 1)
                rep = '{value: '0, error: 1'b1};
            else
                rep = '{value: shadow_stack[0], error: 1'b0};
            if (rep !== known)
                report_mismatch($sformatf("table row expects %0d/%0b, prediction %0d/%0b",
                                          known.value, known.error, rep.value, rep.error));
        end
        send_word(op, opnd);
    endtask

    // Waits for every report and a margin, then writes the limit register.
    task automatic write_limit(input logic [LIM_W-1:0] lim);
        int guard;
        guard = 0;
        while (pending_reports.size() != 0 && guard < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        // A word that makes no report may still be in the divider.
        repeat (40) @(negedge clk);
        cfg_data = lim;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        shadow_limit = lim;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Output side: random stall bursts on out_ready, then check each report.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                stall = $urandom_range(1, 17);
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
                report_mismatch("report with nothing expected");
            else
            begin
                report_t exp_rep;
                exp_rep = pending_reports.pop_front();
                if (result_error !== exp_rep.error)
                    report_mismatch($sformatf("result_error %b, expected %b",
                                              result_error, exp_rep.error));
                if (result_value !== exp_rep.value)
                    report_mismatch($sformatf("result_value %0d, expected %0d",
                                              result_value, exp_rep.value));
                if (exp_rep.error) error_reports++;
            end
        end
    end

    // Watchdog: counts cycles in which no channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || drain_done ||
            (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d reports outstanding", pending_reports.size());
            $display("checked_stack_machine_unit regression: fail");
            $finish;
        end
    end

    // Directed table: extremes, every opcode but SUB, and the error kinds but a full stack. A known
    // figure is typed only where it is obvious; other rows rely on the predictor.
    typedef struct {
        logic [3:0] op;
        logic signed [31:0] opnd;
        bit has_known;
        report_t known;
    } row_t;

    localparam report_t ERR = '{value: '0, error: 1'b1};
    localparam report_t NONE = '{value: '0, error: 1'b0};

    row_t directed_rows [33] = '{
        '{OP_FINISH, 32'sd0, 1, ERR},                      // empty stack after reset
        '{OP_START, 32'sd1000000000, 0, NONE},
        '{OP_FINISH, 32'sd0, 1, '{value: 31'sd1000000000, error: 1'b0}},
        '{OP_START, -32'sd1000000000, 0, NONE},
        '{OP_FINISH, 32'sd0, 1, '{value: -31'sd1000000000, error: 1'b0}},
        '{OP_START, 32'sd1000000001, 0, NONE},             // start value beyond limit
        '{OP_FINISH, 32'sd0, 1, ERR},
        '{OP_START, 32'sd7, 0, NONE},
        '{OP_NUM, 32'sh80000000, 0, NONE},                 // literal beyond limit
        '{OP_FINISH, 32'sd0, 1, ERR},
        '{OP_START, -32'sd7, 0, NONE},
        '{OP_NUM, 32'sd2, 0, NONE},
        '{OP_MOD, 32'sd0, 0, NONE},                        // remainder takes the sign of a
        '{OP_NUM, 32'sd3, 0, NONE},
        '{OP_SWP, 32'sd0, 0, NONE},
        '{OP_DIV, 32'sd0, 0, NONE},
        '{OP_INV, 32'sd0, 0, NONE},
        '{OP_DUP, 32'sd0, 0, NONE},
        '{OP_MUL, 32'sd0, 0, NONE},
        '{OP_FINISH, 32'sd0, 0, NONE},
        '{OP_START, 32'sd5, 0, NONE},
        '{OP_NUM, 32'sd0, 0, NONE},
        '{OP_DIV, 32'sd0, 0, NONE},                        // zero divisor
        '{OP_FINISH, 32'sd0, 1, ERR},
        '{OP_START, 32'sd0, 0, NONE},
        '{OP_POP, 32'sd0, 0, NONE},
        '{OP_INV, 32'sd0, 0, NONE},                        // inversion of an empty stack
        '{OP_NUM, 32'sd1, 0, NONE},                        // ignored after the fault
        '{OP_FINISH, 32'sd0, 1, ERR},
        '{4'd15, -32'sd1, 0, NONE},                        // unused opcode
        '{OP_START, 32'sd9, 0, NONE},
        '{OP_ADD, 32'sd0, 0, NONE},                        // underflow on arithmetic
        '{OP_FINISH, 32'sd0, 1, ERR}
    };

    function automatic logic signed [31:0] pick_value(input int unsigned span);
        case ($urandom_range(0, 5))
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(0, 2 * span))) - $signed(32'(span));
            default: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
        endcase
    endfunction

    // One random program: mostly well-formed, with occasional faults and noise.
    task automatic random_program(input int unsigned span);
        int unsigned n;
        int unsigned k;
        logic [3:0] op;
        send_word(OP_START, pick_value(span));
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++)
        begin
            if (shadow_depth < 2 && $urandom_range(0, 9) != 0)
                op = ($urandom_range(0, 2) == 0) ? OP_DUP : OP_NUM;
            else
                op = 4'($urandom_range(0, 9));
            if ($urandom_range(0, 29) == 0)
                op = 4'($urandom_range(12, 15));
            send_word(op, pick_value(span));
        end
        // Fold the stack down to one entry most of the time.
        while (!shadow_fault && shadow_depth > 1 && $urandom_range(0, 7) != 0)
            send_word(4'($urandom_range(OP_ADD, OP_MOD)), $signed($urandom()));
        send_word(OP_FINISH, $signed($urandom()));
    endtask

    initial
    begin
        int unsigned idx;
        logic [LIM_W-1:0] limits [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_NUM;
        operand = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm_phase = 1'b0;
        drain_done = 1'b0;
        mismatch_count = 0;
        words_sent = 0;
        reports_seen = 0;
        error_reports = 0;
        quiet_cycles = 0;
        shadow_depth = 0;
        shadow_fault = 1'b0;
        shadow_limit = LIMIT_RESET;
        for (idx = 0; idx < STACK_DEPTH; idx++)
            shadow_stack[idx] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
            send_known(directed_rows[r].op, directed_rows[r].opnd,
                       directed_rows[r].has_known, directed_rows[r].known);

        // Sweep the limit, extremes included; small limits make faults common.
        limits[0] = 30'd0;
        limits[1] = 30'h3FFFFFFF;
        limits[2] = 30'd50;
        limits[3] = LIMIT_RESET;
        for (idx = 0; idx < 4; idx++)
        begin
            write_limit(limits[idx]);
            while (words_sent < 70 * (idx + 1) + 33)
                random_program(idx == 2 ? 60 : 1000000000);
        end

        // Last stretch with no idling on either side.
        calm_phase = 1'b1;
        repeat (8) random_program(1000);

        while (pending_reports.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        drain_done = 1'b1;
        $display("Sent %0d instruction words over four limit settings.", words_sent);
        $display("Checked %0d reports, %0d of them flagged as errors.", reports_seen, error_reports);
        if (mismatch_count == 0)
            $display("checked_stack_machine_unit regression: pass");
        else
            $display("checked_stack_machine_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
